/* rtl/core/lzss_window_decompressor_macros.svh */
// Assertion helpers
`ifndef LZSS_WINDOW_DECOMPRESSOR_MACROS_SVH
`define LZSS_WINDOW_DECOMPRESSOR_MACROS_SVH

`ifndef SYNTHESIS
`define LZWD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lzss window decompressor assertion failed");
`define LZWD_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("lzss window decompressor reset assertion failed");
`else
`define LZWD_ASSERT(lbl, clk, rst_n, prop)
`define LZWD_ASSERT_NR(lbl, clk, prop)
`endif

`endif

/* rtl/core/lzwd_pkg.sv */
package lzwd_pkg;

    localparam int WINDOW_DEPTH = 4096;
    localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
    localparam int LEN_W        = 24;
    localparam int REM_W        = 5;
    localparam int BYTE_W       = 8;
    localparam int APB_AW       = 3;
    localparam int APB_DW       = 32;

    localparam logic [REM_W-1:0]  LEN_BIAS        = REM_W'(3);
    localparam logic [APB_AW-1:0] ADDR_OUTPUT_LEN = APB_AW'(0);

    typedef enum logic {
        S_IDLE,
        S_COPY
    } t_state;

    typedef enum logic [1:0] {
        PH_CTRL,
        PH_ITEM,
        PH_HIGH
    } t_phase;

endpackage

/* rtl/core/lzss_window_decompressor.sv */
// A literal word reaches the output register in the cycle after it is accepted. A match
// word reads its first byte from the window as its high byte is taken, then gives one
// byte per cycle while the output is not stalled (3 to 18, cut at the output length).
// The window has one read port; input is stalled during the copy. Control and low bytes
// give nothing. Reset is synchronous and clears control state; the window is not swept
// after reset or stream start: a fill mark makes entries not yet written read as zero.
`include "lzss_window_decompressor_macros.svh"

module lzss_window_decompressor (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // slave stream
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [lzwd_pkg::BYTE_W-1:0]   i_s_tdata,   // [7:0] data_byte
    input  logic                          i_s_tuser,   // [0] stream_start
    // master stream
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [lzwd_pkg::BYTE_W-1:0]   o_m_tdata,   // [7:0] out_byte
    output logic                          o_m_tlast,   // last_of_run
    output logic                          o_m_tuser,   // [0] stream_done
    // config port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lzwd_pkg::APB_AW-1:0]   paddr,
    input  logic [lzwd_pkg::APB_DW-1:0]   pwdata,
    output logic [lzwd_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import lzwd_pkg::*;

    logic [BYTE_W-1:0] r_window [WINDOW_DEPTH];

    t_state             r_state,     n_state;
    t_phase             r_phase,     n_phase;
    logic [WIN_AW-1:0]  r_wp,        n_wp;
    logic               r_wrap,      n_wrap;
    logic [BYTE_W-1:0]  r_flag,      n_flag;
    logic [2:0]         r_pos,       n_pos;
    logic [BYTE_W-1:0]  r_held,      n_held;
    logic [LEN_W-1:0]   r_prod,      n_prod;
    logic [LEN_W-1:0]   r_len;
    logic [WIN_AW-1:0]  r_rd,        n_rd;
    logic [REM_W-1:0]   r_remaining, n_remaining;
    logic               r_fwd,       n_fwd;
    logic [BYTE_W-1:0]  r_fwd_data,  n_fwd_data;
    logic               r_rd_ok,     n_rd_ok;
    logic [BYTE_W-1:0]  r_rdata;

    logic               r_out_valid;
    logic [BYTE_W-1:0]  r_out_data;
    logic               r_out_last;
    logic               r_out_done;

    logic               out_free;
    logic               in_fire;
    logic               mem_we;
    logic               mem_re;
    logic [WIN_AW-1:0]  mem_waddr;
    logic [WIN_AW-1:0]  mem_raddr;
    logic [BYTE_W-1:0]  mem_wdata;
    logic               ld_out;
    logic [BYTE_W-1:0]  ld_data;
    logic               ld_last;
    logic               ld_done;
    logic               copy_last;

    t_phase             e_phase;
    logic [WIN_AW-1:0]  e_wp;
    logic               e_wrap;
    logic [BYTE_W-1:0]  e_flag;
    logic [2:0]         e_pos;
    logic [BYTE_W-1:0]  e_held;
    logic [LEN_W-1:0]   e_prod;
    logic [LEN_W-1:0]   prod_inc;
    logic [BYTE_W-1:0]  cur_byte;
    logic [WIN_AW-1:0]  rd_next;

    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE) && out_free;
    assign in_fire    = i_s_tvalid && o_s_tready;

    assign pready = 1'b1;
    assign prdata = APB_DW'(r_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_OUTPUT_LEN) begin
            r_len <= pwdata[LEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_window[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_window[mem_raddr];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_wp        = r_wp;
        n_wrap      = r_wrap;
        n_flag      = r_flag;
        n_pos       = r_pos;
        n_held      = r_held;
        n_prod      = r_prod;
        n_rd        = r_rd;
        n_remaining = r_remaining;
        n_fwd       = r_fwd;
        n_fwd_data  = r_fwd_data;
        n_rd_ok     = r_rd_ok;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = r_wp;
        mem_raddr   = r_rd;
        mem_wdata   = '0;
        ld_out      = 1'b0;
        ld_data     = '0;
        ld_last     = 1'b0;
        ld_done     = 1'b0;
        copy_last   = 1'b0;
        cur_byte    = r_fwd ? r_fwd_data : (r_rd_ok ? r_rdata : '0);
        rd_next     = r_rd + WIN_AW'(1);

        if (i_s_tuser) begin
            e_phase = PH_CTRL;
            e_wp    = '0;
            e_wrap  = 1'b0;
            e_flag  = '0;
            e_pos   = '0;
            e_held  = '0;
            e_prod  = '0;
        end else begin
            e_phase = r_phase;
            e_wp    = r_wp;
            e_wrap  = r_wrap;
            e_flag  = r_flag;
            e_pos   = r_pos;
            e_held  = r_held;
            e_prod  = r_prod;
        end
        prod_inc = (r_state == S_IDLE) ? e_prod + LEN_W'(1) : r_prod + LEN_W'(1);

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_phase = e_phase;
                    n_wp    = e_wp;
                    n_wrap  = e_wrap;
                    n_flag  = e_flag;
                    n_pos   = e_pos;
                    n_held  = e_held;
                    n_prod  = e_prod;
                    if (e_prod < r_len) begin
                        unique case (e_phase)
                            PH_CTRL: begin
                                n_flag  = i_s_tdata;
                                n_pos   = '0;
                                n_phase = PH_ITEM;
                            end
                            PH_ITEM: begin
                                if (e_flag[e_pos]) begin
                                    mem_we    = 1'b1;
                                    mem_waddr = e_wp;
                                    mem_wdata = i_s_tdata;
                                    n_wp      = e_wp + WIN_AW'(1);
                                    n_wrap    = e_wrap || (&e_wp);
                                    n_prod    = prod_inc;
                                    ld_out    = 1'b1;
                                    ld_data   = i_s_tdata;
                                    ld_last   = 1'b1;
                                    ld_done   = prod_inc >= r_len;
                                    n_pos     = e_pos + 3'd1;
                                    n_phase   = (n_pos == '0) ? PH_CTRL : PH_ITEM;
                                end else begin
                                    n_held  = i_s_tdata;
                                    n_phase = PH_HIGH;
                                end
                            end
                            PH_HIGH: begin
                                mem_re      = 1'b1;
                                mem_raddr   = {i_s_tdata[3:0], e_held};
                                n_rd        = mem_raddr;
                                n_remaining = REM_W'(i_s_tdata[7:4]) + LEN_BIAS;
                                n_fwd       = 1'b0;
                                n_rd_ok     = e_wrap || (mem_raddr < e_wp);
                                n_state     = S_COPY;
                            end
                            default: begin
                                n_phase = PH_CTRL;
                            end
                        endcase
                    end
                end
            end
            S_COPY: begin
                if (out_free) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_wp;
                    mem_wdata = cur_byte;
                    n_wp      = r_wp + WIN_AW'(1);
                    n_wrap    = r_wrap || (&r_wp);
                    n_prod    = prod_inc;
                    copy_last = (prod_inc >= r_len) || (r_remaining == REM_W'(1));
                    ld_out    = 1'b1;
                    ld_data   = cur_byte;
                    ld_last   = copy_last;
                    ld_done   = prod_inc >= r_len;
                    if (copy_last) begin
                        n_state = S_IDLE;
                        n_pos   = r_pos + 3'd1;
                        n_phase = (n_pos == '0) ? PH_CTRL : PH_ITEM;
                    end else begin
                        mem_re      = 1'b1;
                        mem_raddr   = rd_next;
                        n_rd        = rd_next;
                        n_remaining = r_remaining - REM_W'(1);
                        n_fwd       = rd_next == r_wp;
                        n_fwd_data  = cur_byte;
                        n_rd_ok     = n_wrap || (rd_next < n_wp);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_CTRL;
            r_wp        <= '0;
            r_wrap      <= 1'b0;
            r_flag      <= '0;
            r_pos       <= '0;
            r_held      <= '0;
            r_prod      <= '0;
            r_remaining <= '0;
            r_fwd       <= 1'b0;
            r_rd_ok     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_wp        <= n_wp;
            r_wrap      <= n_wrap;
            r_flag      <= n_flag;
            r_pos       <= n_pos;
            r_held      <= n_held;
            r_prod      <= n_prod;
            r_remaining <= n_remaining;
            r_fwd       <= n_fwd;
            r_rd_ok     <= n_rd_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd       <= n_rd;
        r_fwd_data <= n_fwd_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ld_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_out) begin
            r_out_data <= ld_data;
            r_out_last <= ld_last;
            r_out_done <= ld_done;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_done;

    `LZWD_ASSERT(a_no_input_in_copy, i_clk, i_rst_n, (r_state == S_COPY) |-> !o_s_tready)
    `LZWD_ASSERT(a_copy_has_bytes, i_clk, i_rst_n, (r_state == S_COPY) |-> (r_remaining != '0))
    `LZWD_ASSERT(a_last_ends_copy, i_clk, i_rst_n, (r_state == S_COPY && ld_out && copy_last) |=> (r_state == S_IDLE && r_out_last))
    `LZWD_ASSERT_NR(a_reset_clears_out, i_clk, !i_rst_n |=> (!r_out_valid && r_state == S_IDLE))

endmodule

/* tb/lzwd_output_checker.sv */
module lzwd_output_checker
    import lzwd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    input  logic              i_s_tready,
    input  logic [BYTE_W-1:0] i_s_tdata,
    input  logic              i_s_tuser,
    input  logic              i_m_tvalid,
    input  logic              i_m_tready,
    input  logic [BYTE_W-1:0] i_m_tdata,
    input  logic              i_m_tlast,
    input  logic              i_m_tuser,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    input  logic              pready,
    output int                o_errors,
    output int                o_pending
);

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              run_end;
        logic              done;
    } t_out_word;

    logic [BYTE_W-1:0] window_mem [WINDOW_DEPTH];
    logic [WIN_AW-1:0] wr_ptr;
    logic [BYTE_W-1:0] flags;
    logic [2:0]        flag_pos;
    t_phase            phase;
    logic [BYTE_W-1:0] low_byte;
    logic [LEN_W-1:0]  produced;
    logic [LEN_W-1:0]  out_len;
    t_out_word         expected_words [$];

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    task automatic clear_stream();
        for (int i = 0; i < WINDOW_DEPTH; i++) begin
            window_mem[i] = '0;
        end
        wr_ptr   = '0;
        flags    = '0;
        flag_pos = '0;
        phase    = PH_CTRL;
        low_byte = '0;
        produced = '0;
    endtask

    task automatic advance_flag();
        flag_pos = flag_pos + 1'b1;
        phase    = (flag_pos == 3'd0) ? PH_CTRL : PH_ITEM;
    endtask

    task automatic emit_byte(input logic [BYTE_W-1:0] b, input logic run_end);
        t_out_word w;
        window_mem[wr_ptr] = b;
        wr_ptr    = wr_ptr + 1'b1;
        produced  = produced + 1'b1;
        w.data    = b;
        w.run_end = run_end;
        w.done    = (produced >= out_len);
        expected_words.push_back(w);
    endtask

    task automatic decode_word(input logic [BYTE_W-1:0] b, input logic start);
        logic [15:0]       match;
        logic [WIN_AW-1:0] rd;
        logic [LEN_W-1:0]  count;
        logic [LEN_W-1:0]  remaining;
        if (start) begin
            clear_stream();
        end
        if (produced >= out_len) begin
            return;
        end
        case (phase)
            PH_CTRL: begin
                flags    = b;
                flag_pos = '0;
                phase    = PH_ITEM;
            end
            PH_ITEM: begin
                if (flags[flag_pos]) begin
                    emit_byte(b, 1'b1);
                    advance_flag();
                end else begin
                    low_byte = b;
                    phase    = PH_HIGH;
                end
            end
            default: begin
                match     = {b, low_byte};
                rd        = match[WIN_AW-1:0];
                count     = LEN_W'(match[15:12]) + LEN_W'(LEN_BIAS);
                remaining = out_len - produced;
                if (count > remaining) begin
                    count = remaining;
                end
                for (int i = 0; i < int'(count); i++) begin
                    emit_byte(window_mem[rd], i == int'(count) - 1);
                    rd = rd + 1'b1;
                end
                advance_flag();
            end
        endcase
    endtask

    always @(posedge i_clk) begin : monitor
        t_out_word w;
        if (!i_rst_n) begin
            clear_stream();
            out_len = '0;
            expected_words.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == ADDR_OUTPUT_LEN) begin
                out_len = pwdata[LEN_W-1:0];
            end
            if (i_s_tvalid && i_s_tready) begin
                decode_word(i_s_tdata, i_s_tuser);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (expected_words.size() == 0) begin
                    o_errors++;
                    $display("%0t: unexpected word data %02h last %0b done %0b",
                             $time, i_m_tdata, i_m_tlast, i_m_tuser);
                end else begin
                    w = expected_words.pop_front();
                    if (w.data !== i_m_tdata) begin
                        o_errors++;
                        $display("%0t: out_byte expected %02h actual %02h",
                                 $time, w.data, i_m_tdata);
                    end
                    if (w.run_end !== i_m_tlast) begin
                        o_errors++;
                        $display("%0t: last_of_run expected %0b actual %0b",
                                 $time, w.run_end, i_m_tlast);
                    end
                    if (w.done !== i_m_tuser) begin
                        o_errors++;
                        $display("%0t: stream_done expected %0b actual %0b",
                                 $time, w.done, i_m_tuser);
                    end
                end
            end
        end
        o_pending <= expected_words.size();
    end

endmodule

/* tb/lzss_window_decompressor_test.sv */
module lzss_window_decompressor_test;
    import lzwd_pkg::*;

    localparam int HOLD_CYCLES   = 400;
    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 24;
    localparam int WORD_TARGET   = 290;
    localparam int CALM_AFTER    = 230;
    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_s_tvalid;
    logic              o_s_tready;
    logic [BYTE_W-1:0] i_s_tdata;
    logic              i_s_tuser;
    logic              o_m_tvalid;
    logic              i_m_tready;
    logic [BYTE_W-1:0] o_m_tdata;
    logic              o_m_tlast;
    logic              o_m_tuser;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int error_count;
    int pending_words;
    int quiet_cycles = 0;
    int words_sent   = 0;
    bit gaps_on      = 1'b1;
    bit hold_long    = 1'b0;

    lzss_window_decompressor DUT (.*);

    lzwd_output_checker checker_i (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_m_tdata  (o_m_tdata),
        .i_m_tlast  (o_m_tlast),
        .i_m_tuser  (o_m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .o_errors   (error_count),
        .o_pending  (pending_words)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : sink
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_long) begin
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
                hold_long = 1'b0;
            end else if (gaps_on && $urandom_range(0, 4) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 9) - 1) @(posedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    task automatic send_word(input logic [BYTE_W-1:0] d, input logic start);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= d;
        i_s_tuser  <= start;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic cfg_write(input logic [LEN_W-1:0] len);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_OUTPUT_LEN;
        pwdata  <= {8'($urandom), len};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_words != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // favor copies from just behind the write position so they overlap their own output
    function automatic logic [15:0] pick_match(input int written);
        logic [WIN_AW-1:0] pos;
        logic [3:0]        len;
        len = 4'($urandom);
        if (written > 0 && $urandom_range(0, 9) < 7) begin
            pos = WIN_AW'(written - $urandom_range(1, (written < 24) ? written : 24));
        end else begin
            pos = WIN_AW'($urandom);
        end
        return {len, pos};
    endfunction

    task automatic send_stream(input int goal, input int budget);
        logic [BYTE_W-1:0] ctrl;
        logic [15:0]       match;
        int                emitted;
        int                used;
        bit                first;
        emitted = 0;
        used    = 0;
        first   = 1'b1;
        while (emitted < goal && used < budget) begin
            ctrl = 8'($urandom);
            send_word(ctrl, first);
            first = 1'b0;
            used++;
            for (int f = 0; f < 8 && emitted < goal; f++) begin
                if (ctrl[f]) begin
                    send_word(8'($urandom), 1'b0);
                    emitted++;
                    used++;
                end else begin
                    match = pick_match(emitted);
                    send_word(match[7:0], 1'b0);
                    send_word(match[15:8], 1'b0);
                    emitted += int'(match[15:12]) + int'(LEN_BIAS);
                    used += 2;
                end
            end
        end
    endtask

    task automatic send_noise(input int n);
        for (int i = 0; i < n; i++) begin
            send_word(8'($urandom), $urandom_range(0, 7) == 0);
        end
    endtask

    initial begin : stimulus
        int stream_len;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // length still zero after reset: drop everything
        send_word(8'hFF, 1'b1);
        send_word(8'h00, 1'b0);
        drain();

        // two literals, a short copy, then a long copy cut at the length
        cfg_write(LEN_W'(8));
        send_word(8'hF3, 1'b1);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'h01, 1'b0);
        send_word(8'hF0, 1'b0);
        send_word(8'hA5, 1'b0);
        send_word(8'h5A, 1'b0);
        drain();

        // longest copy from the unwritten top of the window
        cfg_write(LEN_MAX);
        send_word(8'h00, 1'b1);
        send_word(8'hFF, 1'b0);
        send_word(8'hFF, 1'b0);
        drain();

        // lower the length below the count, then raise it and resume
        cfg_write(LEN_W'(5));
        send_word(8'h55, 1'b0);
        drain();
        cfg_write(LEN_W'(20));
        send_word(8'h12, 1'b0);
        send_word(8'h00, 1'b0);
        drain();

        cfg_write(LEN_W'(1));
        send_word(8'h01, 1'b1);
        send_word(8'h80, 1'b0);
        send_word(8'h7F, 1'b0);
        drain();

        // stall the sink long enough to back up the input
        gaps_on   = 1'b0;
        cfg_write(LEN_MAX);
        hold_long = 1'b1;
        send_stream(int'(LEN_MAX), 60);
        drain();

        stream_len = 1;
        while (words_sent < WORD_TARGET) begin
            gaps_on = (words_sent < CALM_AFTER) && ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0: begin
                    stream_len = 0;
                    cfg_write('0);
                    send_noise(3);
                end
                1: begin
                    stream_len = int'(LEN_MAX);
                    cfg_write(LEN_MAX);
                    send_stream(stream_len, $urandom_range(8, 30));
                end
                2: begin
                    stream_len = int'(LEN_W'($urandom));
                    cfg_write(LEN_W'(stream_len));
                    send_stream(stream_len, $urandom_range(8, 30));
                end
                3: begin
                    send_stream(stream_len, $urandom_range(8, 40));
                end
                default: begin
                    stream_len = $urandom_range(1, 120);
                    cfg_write(LEN_W'(stream_len));
                    send_stream(stream_len, $urandom_range(8, 40));
                end
            endcase
            if ($urandom_range(0, 2) == 0) begin
                send_noise($urandom_range(1, 4));
            end
            drain();
        end

        if (error_count == 0 && pending_words == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/lzwd_pkg.sv
rtl/core/lzss_window_decompressor.sv
tb/lzwd_output_checker.sv
tb/lzss_window_decompressor_test.sv
